FILE: rtl/core/aac_pkg.sv
package aac_pkg;

    localparam int SAMPLE_W = 12;
    localparam int WEIGHT_W = 8;
    localparam int ACC_W    = 20;
    localparam int NUM_W    = 24;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [SAMPLE_W-1:0] ACTIVE_LIMIT = 12'd1023;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 8'd255;

    // level * 255 / 4095 == (level * 261184) >> 22 for every 12-bit level
    localparam int RECIP_W = 18;
    localparam logic [RECIP_W-1:0] BYTE_RECIP = 18'd261184;
    localparam int BYTE_SHIFT = 22;
    localparam int BYTE_PROD_W = SAMPLE_W + RECIP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE      = 3'd5;

    typedef enum logic {
        K_PASS,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [NUM_W-1:0]    num;
        logic [SAMPLE_W-1:0] den;
    } t_job;

    typedef struct packed {
        logic [SAMPLE_W-1:0] range_low;
        logic [SAMPLE_W-1:0] range_high;
        logic [WEIGHT_W-1:0] smoothing_weight;
        logic                invert_output;
        logic                centered_mode;
        logic [SAMPLE_W-1:0] rest_baseline;
    } t_cfg;

endpackage

FILE: rtl/core/aac_front.sv
module aac_front
    import aac_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output t_job                o_job
);

    logic [SAMPLE_W-1:0] offset;
    logic [NUM_W-1:0]    scaled_num;

    assign offset = i_sample - i_cfg.range_low;
    // offset * 4095 as (offset << 12) - offset
    assign scaled_num = {offset, {SAMPLE_W{1'b0}}} - {{(NUM_W-SAMPLE_W){1'b0}}, offset};

    always_comb begin
        o_job.kind = K_PASS;
        o_job.num  = '0;
        o_job.den  = i_cfg.range_high - i_cfg.range_low;
        if (i_cfg.range_high <= i_cfg.range_low) begin
            o_job.num = {{(NUM_W-SAMPLE_W){1'b0}}, i_sample};
        end else if (i_sample <= i_cfg.range_low) begin
            o_job.num = '0;
        end else if (i_sample >= i_cfg.range_high) begin
            o_job.num = {{(NUM_W-SAMPLE_W){1'b0}}, FULL_SCALE};
        end else begin
            o_job.kind = K_DIV;
            o_job.num  = scaled_num;
        end
    end

endmodule

FILE: rtl/core/aac_queue.sv
module aac_queue
    import aac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/aac_back.sv
module aac_back
    import aac_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [SAMPLE_W-1:0] o_level_wide,
    output logic [BYTE_W-1:0]   o_level_byte,
    output logic                o_active
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_UPD,
        S_OUT
    } t_state;

    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam int PROD_W = WEIGHT_W + ACC_W;

    t_state              r_state;
    logic [NUM_W-1:0]    r_rem;
    logic [SAMPLE_W-1:0] r_den;
    logic [STEP_W-1:0]   r_step;
    logic [SAMPLE_W-1:0] r_scaled;
    logic [ACC_W-1:0]    r_acc;
    logic                r_seeded;
    logic [PROD_W-1:0]   r_prod;
    logic                r_up;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_wide;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_active;

    logic [NUM_W-1:0]       shifted_den;
    logic                   take_bit;
    logic [ACC_W-1:0]       x_val;
    logic [ACC_W-1:0]       diff;
    logic [WEIGHT_W-1:0]    weight;
    logic [SAMPLE_W-1:0]    level_raw;
    logic [SAMPLE_W-1:0]    level;
    logic [SAMPLE_W-1:0]    distance;
    logic [BYTE_PROD_W-1:0] byte_prod;
    logic                   act;
    logic                   out_free;

    assign shifted_den = {{(NUM_W-SAMPLE_W){1'b0}}, r_den} << r_step;
    assign take_bit    = (r_rem >= shifted_den);

    assign x_val  = {r_scaled, 8'b0};
    assign diff   = (x_val > r_acc) ? (x_val - r_acc) : (r_acc - x_val);
    assign weight = (i_cfg.smoothing_weight == '0) ? WEIGHT_MAX : i_cfg.smoothing_weight;

    assign level_raw = r_acc[ACC_W-1:8];
    assign level     = i_cfg.invert_output ? (FULL_SCALE - level_raw) : level_raw;
    assign distance  = (level >= i_cfg.rest_baseline) ? (level - i_cfg.rest_baseline)
                                                      : (i_cfg.rest_baseline - level);
    assign act       = i_cfg.centered_mode ? (distance > ACTIVE_LIMIT)
                                           : (level > ACTIVE_LIMIT);
    assign byte_prod = BYTE_PROD_W'(level) * BYTE_PROD_W'(BYTE_RECIP);

    // result register frees up in the same cycle it is taken
    assign out_free  = !r_out_valid || i_pop;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign o_empty      = !r_out_valid;
    assign o_level_wide = r_out_wide;
    assign o_level_byte = r_out_byte;
    assign o_active     = r_out_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_rem    <= i_job.num;
                        r_den    <= i_job.den;
                        r_step   <= STEP_W'(SAMPLE_W - 1);
                        if (i_job.kind == K_DIV) begin
                            r_scaled <= '0;
                            r_state  <= S_DIV;
                        end else begin
                            r_scaled <= i_job.num[SAMPLE_W-1:0];
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_DIV: begin
                    // one restoring quotient bit per cycle, msb first
                    if (take_bit) begin
                        r_rem            <= r_rem - shifted_den;
                        r_scaled[r_step] <= 1'b1;
                    end
                    if (r_step == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(weight) * PROD_W'(diff);
                    r_up    <= (x_val > r_acc);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!r_seeded) begin
                        r_acc    <= x_val;
                        r_seeded <= 1'b1;
                    end else if (r_up) begin
                        r_acc <= r_acc + r_prod[PROD_W-1:8];
                    end else begin
                        r_acc <= r_acc - r_prod[PROD_W-1:8];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_wide   <= level;
                        r_out_byte   <= byte_prod[BYTE_SHIFT +: BYTE_W];
                        r_out_active <= act;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/analog_axis_conditioner_core.sv
// channel   direction  handshake                   payload
// sample    in         push / full                 i_sample[11:0]
// result    out        empty / pop                 o_level_wide[11:0], o_level_byte[7:0], o_active
// config    in         cfg_valid / cfg_ready       i_cfg_index[2:0], i_cfg_data[11:0]
//
// each item in the back end is picked up, passes the one-bit-per-cycle range
// divider, then goes through multiply, average update and output.
// items that need no division skip the divider but still pass the other steps.
// a two-entry queue sits behind the input, so full rises only when it holds two items.
// reset clears the registers to their defaults, the average and the queue.
// a result waiting in the output register stalls the back end only at its last step.
module analog_axis_conditioner_core
    import aac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [SAMPLE_W-1:0]  o_level_wide,
    output logic [BYTE_W-1:0]    o_level_byte,
    output logic                 o_active,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic queue_valid;
    logic queue_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low        <= '0;
            r_cfg.range_high       <= FULL_SCALE;
            r_cfg.smoothing_weight <= '0;
            r_cfg.invert_output    <= 1'b0;
            r_cfg.centered_mode    <= 1'b0;
            r_cfg.rest_baseline    <= 12'd2048;
        end else if (cfg_valid && cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:     r_cfg.range_low        <= i_cfg_data;
                CFG_RANGE_HIGH:    r_cfg.range_high       <= i_cfg_data;
                CFG_SMOOTH_WEIGHT: r_cfg.smoothing_weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_INVERT:        r_cfg.invert_output    <= i_cfg_data[0];
                CFG_CENTERED:      r_cfg.centered_mode    <= i_cfg_data[0];
                CFG_BASELINE:      r_cfg.rest_baseline    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    aac_front u_front (
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .o_job    (front_job)
    );

    aac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    aac_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (queue_valid),
        .i_job        (queue_job),
        .o_job_pop    (queue_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_level_wide (o_level_wide),
        .o_level_byte (o_level_byte),
        .o_active     (o_active)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import aac_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_ROWS = 45;
    localparam int NUM_PHASES = 8;
    localparam int TAIL_CYCLES = 40;
    localparam logic [SAMPLE_W-1:0] BASELINE_RESET = 12'd2048;
    localparam logic [BYTE_W-1:0] LEVEL_BYTE_MAX = 8'd255;
    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = '0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_wide;
        logic [BYTE_W-1:0]   level_byte;
        logic                active;
    } t_level;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        logic                 typed;
        t_level               want;
    } t_row;

    localparam t_level NO_LEVEL = '0;
    localparam t_level TOP_LEVEL = '{FULL_SCALE, LEVEL_BYTE_MAX, 1'b1};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [SAMPLE_W-1:0]  o_level_wide;
    logic [BYTE_W-1:0]    o_level_byte;
    logic                 o_active;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    t_cfg               cal_cfg;
    logic [ACC_W-1:0]   avg_acc;
    logic               avg_seeded;
    t_level             pending_levels[$];
    int                 err_count = 0;
    int                 cycle_count = 0;
    int                 rx_hold = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    logic [SAMPLE_W-1:0] last_sample = '0;

    t_row plan [NUM_ROWS] = '{
        // first item seeds the average, a repeat of it leaves the average alone
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4095, 1'b1, TOP_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4095, 1'b1, TOP_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1024, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1023, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd2048, 1'b0, NO_LEVEL},
        // slowest average, inverted, centered on zero
        '{ROW_WRITE, CFG_SMOOTH_WEIGHT, 12'h001, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_RANGE_LOW,     12'd1000, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_RANGE_HIGH,    12'd3000, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_INVERT,        12'h001, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_CENTERED,      12'h001, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_BASELINE,      12'd0,   1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1000, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd3000, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4095, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd2000, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1001, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd2999, 1'b0, NO_LEVEL},
        // empty range with low == high, upper data bits must be masked off
        '{ROW_WRITE, CFG_RANGE_LOW,     12'd3000, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_RANGE_HIGH,    12'd3000, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_SMOOTH_WEIGHT, 12'hF80, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_INVERT,        12'h002, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_CENTERED,      12'hFFF, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_BASELINE,      12'd4095, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4095, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd3000, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'hAAA,  1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'h555,  1'b0, NO_LEVEL},
        // inverted range is empty too, spare indexes must not disturb anything
        '{ROW_WRITE, CFG_RANGE_LOW,     12'd4095, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_RANGE_HIGH,    12'd0,   1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_SMOOTH_WEIGHT, 12'h0FF, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_CENTERED,      12'hFFE, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_SPARE_LO,      12'hFFF, 1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_SPARE_HI,      12'hFFF, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4094, 1'b0, NO_LEVEL},
        // narrowest real range, weight zero acts as the fastest average
        '{ROW_WRITE, CFG_RANGE_LOW,     12'd0,   1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_RANGE_HIGH,    12'd1,   1'b0, NO_LEVEL},
        '{ROW_WRITE, CFG_SMOOTH_WEIGHT, 12'h000, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd1,    1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd4095, 1'b0, NO_LEVEL},
        '{ROW_SAMPLE, IDX_UNUSED, 12'd0,    1'b0, NO_LEVEL}
    };

    analog_axis_conditioner_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_level_wide (o_level_wide),
        .o_level_byte (o_level_byte),
        .o_active     (o_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 48);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return FULL_SCALE;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_RANGE_LOW:     cal_cfg.range_low = data[SAMPLE_W-1:0];
            CFG_RANGE_HIGH:    cal_cfg.range_high = data[SAMPLE_W-1:0];
            CFG_SMOOTH_WEIGHT: cal_cfg.smoothing_weight = data[WEIGHT_W-1:0];
            CFG_INVERT:        cal_cfg.invert_output = data[0];
            CFG_CENTERED:      cal_cfg.centered_mode = data[0];
            CFG_BASELINE:      cal_cfg.rest_baseline = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endfunction

    // rescale, update the average, then invert and judge activity
    function automatic t_level track_level(input logic [SAMPLE_W-1:0] s);
        t_level              r;
        logic [SAMPLE_W-1:0] scaled;
        logic [SAMPLE_W-1:0] lvl;
        logic [SAMPLE_W-1:0] distance;
        logic [ACC_W-1:0]    x;
        logic [WEIGHT_W-1:0] w;
        if (cal_cfg.range_high <= cal_cfg.range_low)
            scaled = s;
        else if (s <= cal_cfg.range_low)
            scaled = '0;
        else if (s >= cal_cfg.range_high)
            scaled = FULL_SCALE;
        else
            scaled = SAMPLE_W'((24'(s - cal_cfg.range_low) * 24'(FULL_SCALE))
                               / 24'(cal_cfg.range_high - cal_cfg.range_low));
        x = {scaled, 8'h00};
        w = (cal_cfg.smoothing_weight == '0) ? WEIGHT_MAX : cal_cfg.smoothing_weight;
        if (!avg_seeded) begin
            avg_acc = x;
            avg_seeded = 1'b1;
        end else if (x > avg_acc) begin
            avg_acc = avg_acc + ACC_W'((28'(w) * 28'(x - avg_acc)) >> 8);
        end else begin
            avg_acc = avg_acc - ACC_W'((28'(w) * 28'(avg_acc - x)) >> 8);
        end
        lvl = avg_acc[ACC_W-1:8];
        if (cal_cfg.invert_output)
            lvl = FULL_SCALE - lvl;
        if (cal_cfg.centered_mode)
            distance = (lvl >= cal_cfg.rest_baseline) ? lvl - cal_cfg.rest_baseline
                                                      : cal_cfg.rest_baseline - lvl;
        else
            distance = lvl;
        r.level_wide = lvl;
        r.level_byte = BYTE_W'((20'(lvl) * 20'(LEVEL_BYTE_MAX)) / 20'(FULL_SCALE));
        r.active = (distance > ACTIVE_LIMIT);
        return r;
    endfunction

    // push stays high after an accepted item unless a gap follows
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input t_level want);
        t_level lv;
        push <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        lv = track_level(s);
        pending_levels.push_back(typed ? want : lv);
        last_sample = s;
        if (tx_idle_on && $urandom_range(0, 99) < 30) begin
            push <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
    endtask

    // cfg_valid is left high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        set_reg(idx, data);
    endtask

    task automatic random_setup();
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] t;
        logic [CFG_DAT_W-1:0] wdata;
        int r;
        wait_idle();
        a = pick_code();
        b = pick_code();
        // keep most ranges usable, a few stay empty or reversed
        if ($urandom_range(0, 9) < 8 && a > b) begin
            t = a;
            a = b;
            b = t;
        end
        write_reg(CFG_RANGE_LOW, a);
        write_reg(CFG_RANGE_HIGH, b);
        wdata = CFG_DAT_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 2)
            wdata[WEIGHT_W-1:0] = '0;
        else if (r < 4)
            wdata[WEIGHT_W-1:0] = WEIGHT_MAX;
        else if (r < 5)
            wdata[WEIGHT_W-1:0] = 8'd1;
        write_reg(CFG_SMOOTH_WEIGHT, wdata);
        write_reg(CFG_INVERT, CFG_DAT_W'($urandom));
        write_reg(CFG_CENTERED, CFG_DAT_W'($urandom));
        write_reg(CFG_BASELINE, pick_code());
        if ($urandom_range(0, 9) < 3)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DAT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return SAMPLE_W'($urandom);
            4:       return $urandom_range(0, 1) ? FULL_SCALE : '0;
            5:       return cal_cfg.range_low + SAMPLE_W'($urandom_range(0, 2)) - 12'd1;
            6:       return cal_cfg.range_high + SAMPLE_W'($urandom_range(0, 2)) - 12'd1;
            default: return last_sample;
        endcase
    endfunction

    // result side: check every popped item, then pick the next pop level
    always @(posedge i_clk) begin : result_side
        t_level want;
        if (i_rst_n && pop && !empty) begin
            if (pending_levels.size() == 0) begin
                report($sformatf("unexpected item level_wide=%0d", o_level_wide));
            end else begin
                want = pending_levels.pop_front();
                if (o_level_wide !== want.level_wide)
                    report($sformatf("level_wide got %0d want %0d",
                                     o_level_wide, want.level_wide));
                if (o_level_byte !== want.level_byte)
                    report($sformatf("level_byte got %0d want %0d",
                                     o_level_byte, want.level_byte));
                if (o_active !== want.active)
                    report($sformatf("active got %0b want %0b", o_active, want.active));
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold != 0) begin
            pop <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
            pop <= 1'b0;
            rx_hold <= pick_gap() - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        bit prev_write;
        int n;
        cal_cfg = '{'0, FULL_SCALE, '0, 1'b0, 1'b0, BASELINE_RESET};
        avg_acc = '0;
        avg_seeded = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_write = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!prev_write)
                    wait_idle();
                write_reg(plan[i].idx, plan[i].val);
                prev_write = 1'b1;
            end else begin
                if (prev_write)
                    cfg_valid <= 1'b0;
                send_sample(plan[i].val, plan[i].typed, plan[i].want);
                prev_write = 1'b0;
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            random_setup();
            // first phase runs flat out on both sides
            tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            n = $urandom_range(100, 150);
            for (int k = 0; k < n; k++) begin
                if (ph == 2 && k == n / 2)
                    wait_idle();
                send_sample(pick_sample(), 1'b0, NO_LEVEL);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_levels.size() != 0)
            report($sformatf("%0d items never came out", pending_levels.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
